// ===== hw/rtl/indexed_min_heap_queue_top_macros.svh =====
// Assertion macros for the indexed min-heap queue
`ifndef INDEXED_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IMHQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMHQ_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMHQ_ASSERT(label, clk, rst_n, prop, msg)
`define IMHQ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/imhq_pkg.sv =====
package imhq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_POS_RD,
        S_POS_WAIT,
        S_DECIDE,
        S_RM_RD,
        S_RM_WAIT,
        S_RM_LAST,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMP,
        S_PLACE,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       clr_init;
        logic       clr_step;
        logic       cap_in;
        logic       pos_rd;
        logic       decide;
        logic       rm_rd;
        logic       rm_cap;
        logic       rm_last_cap;
        logic       up_rd;
        logic       up_cmp;
        logic       dn_rd;
        logic       dn_cmp;
        logic       place;
        logic       top_rd;
        logic       top_cap;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       clr_done;
        logic       reject;
        logic [1:0] op;
        logic       go_up;
        logic       up_at_root;
        logic       up_move;
        logic       dn_no_child;
        logic       dn_move;
        logic       rm_to_empty;
    } stat_t;

endpackage

// ===== hw/rtl/imhq_if.sv =====
interface imhq_in_if #(parameter int IdW = 10, parameter int RankW = 32);
    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic [IdW-1:0]   node_id;
    logic [RankW-1:0] new_rank;
    logic             move_up;
    modport source (output valid, op, node_id, new_rank, move_up, input ready);
    modport sink (input valid, op, node_id, new_rank, move_up, output ready);
endinterface

interface imhq_out_if #(parameter int IdW = 10, parameter int RankW = 32,
                        parameter int CntW = 11);
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic             top_valid;
    logic [IdW-1:0]   top_node;
    logic [RankW-1:0] top_rank;
    logic [CntW-1:0]  entry_total;
    modport source (output valid, status, top_valid, top_node, top_rank, entry_total,
                    input ready);
    modport sink (input valid, status, top_valid, top_node, top_rank, entry_total,
                  output ready);
endinterface

// ===== hw/rtl/indexed_min_heap_queue_top.sv =====
// Flow: each item is captured in idle and its position map entry read; a refused item goes
// straight to the root read, otherwise the heap is first walked level by level.
// Throughput: one item at a time; next input taken the cycle after the result transfer.
// Reset: asynchronous, active low; entry count cleared, then a clearing pass over
// every position map entry before the first item is taken.
module indexed_min_heap_queue_top #(
    parameter int CAPACITY = 1024,
    parameter int NODE_IDS = 1024,
    parameter int RANK_WIDTH = 32
) (
    input logic  clk,
    input logic  rst_n,
    imhq_in_if.sink    in_ch,
    imhq_out_if.source out_ch
);
    localparam int IdW = 10;
    localparam int CntW = $clog2(CAPACITY + 1);

    imhq_pkg::cmd_t  cmd;
    imhq_pkg::stat_t stat;
    logic [CntW-1:0] total;

    imhq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd));

    imhq_dp #(.Capacity(CAPACITY), .NodeIds(NODE_IDS), .RankW(RANK_WIDTH),
              .IdW(IdW), .CntW(CntW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_op(in_ch.op), .in_node_id(in_ch.node_id),
        .in_new_rank(in_ch.new_rank), .in_move_up(in_ch.move_up),
        .status(out_ch.status), .top_valid(out_ch.top_valid),
        .top_node(out_ch.top_node), .top_rank(out_ch.top_rank),
        .entry_total(total));

    assign out_ch.entry_total = total;
endmodule

// ===== hw/rtl/imhq_ram.sv =====
module imhq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/imhq_ctrl.sv =====
`include "indexed_min_heap_queue_top_macros.svh"
module imhq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  imhq_pkg::stat_t     stat,
    output imhq_pkg::cmd_t      cmd
);
    imhq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imhq_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imhq_pkg::S_CLEAR:
                if (stat.clr_done) state_next = imhq_pkg::S_IDLE;
            imhq_pkg::S_IDLE:
                if (in_valid) state_next = imhq_pkg::S_POS_RD;
            imhq_pkg::S_POS_RD:   state_next = imhq_pkg::S_POS_WAIT;
            imhq_pkg::S_POS_WAIT: state_next = imhq_pkg::S_DECIDE;
            imhq_pkg::S_DECIDE:
            begin
                priority if (stat.reject)
                    state_next = imhq_pkg::S_TOP_RD;
                else if (stat.op == imhq_pkg::OP_INSERT)
                    state_next = imhq_pkg::S_UP_RD;
                else if (stat.op == imhq_pkg::OP_REMOVE)
                    state_next = imhq_pkg::S_RM_RD;
                else if (stat.op == imhq_pkg::OP_MODIFY)
                    state_next = stat.go_up ? imhq_pkg::S_UP_RD : imhq_pkg::S_DN_RD;
                else
                    state_next = imhq_pkg::S_TOP_RD;
            end
            imhq_pkg::S_RM_RD:   state_next = imhq_pkg::S_RM_WAIT;
            imhq_pkg::S_RM_WAIT: state_next = imhq_pkg::S_RM_LAST;
            imhq_pkg::S_RM_LAST:
                state_next = stat.rm_to_empty ? imhq_pkg::S_TOP_RD : imhq_pkg::S_DN_RD;
            imhq_pkg::S_UP_RD:
                state_next = stat.up_at_root ? imhq_pkg::S_PLACE : imhq_pkg::S_UP_WAIT;
            imhq_pkg::S_UP_WAIT: state_next = imhq_pkg::S_UP_CMP;
            imhq_pkg::S_UP_CMP:
                state_next = stat.up_move ? imhq_pkg::S_UP_RD : imhq_pkg::S_PLACE;
            imhq_pkg::S_DN_RD:
                state_next = stat.dn_no_child ? imhq_pkg::S_PLACE : imhq_pkg::S_DN_WAIT;
            imhq_pkg::S_DN_WAIT: state_next = imhq_pkg::S_DN_CMP;
            imhq_pkg::S_DN_CMP:
                state_next = stat.dn_move ? imhq_pkg::S_DN_RD : imhq_pkg::S_PLACE;
            imhq_pkg::S_PLACE:    state_next = imhq_pkg::S_TOP_RD;
            imhq_pkg::S_TOP_RD:   state_next = imhq_pkg::S_TOP_WAIT;
            imhq_pkg::S_TOP_WAIT: state_next = imhq_pkg::S_OUT;
            imhq_pkg::S_OUT:
                if (out_ready) state_next = imhq_pkg::S_IDLE;
            default: state_next = imhq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            imhq_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            imhq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.cap_in = 1'b1;
            end
            imhq_pkg::S_POS_RD:  cmd.pos_rd = 1'b1;
            imhq_pkg::S_DECIDE:  cmd.decide = 1'b1;
            imhq_pkg::S_RM_RD:   cmd.rm_rd = 1'b1;
            // hold the read addresses through the wait cycles
            imhq_pkg::S_RM_WAIT:
            begin
                cmd.rm_rd = 1'b1;
                cmd.rm_cap = 1'b1;
            end
            imhq_pkg::S_RM_LAST: cmd.rm_last_cap = 1'b1;
            imhq_pkg::S_UP_RD:   cmd.up_rd = 1'b1;
            imhq_pkg::S_UP_WAIT: cmd.up_rd = 1'b1;
            imhq_pkg::S_UP_CMP:  cmd.up_cmp = 1'b1;
            imhq_pkg::S_DN_RD:   cmd.dn_rd = 1'b1;
            imhq_pkg::S_DN_WAIT: cmd.dn_rd = 1'b1;
            imhq_pkg::S_DN_CMP:  cmd.dn_cmp = 1'b1;
            imhq_pkg::S_PLACE:   cmd.place = 1'b1;
            imhq_pkg::S_TOP_RD:  cmd.top_rd = 1'b1;
            imhq_pkg::S_TOP_WAIT: cmd.top_cap = 1'b1;
            imhq_pkg::S_OUT:     out_valid = 1'b1;
            default: ;
        endcase
        cmd.clr_init = 1'b0;
    end

    `IMHQ_ASSERT(a_ready_only_idle, clk, rst_n, in_ready |-> state_reg == imhq_pkg::S_IDLE, "ready outside idle")
    `IMHQ_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "input and output at once")
    `IMHQ_ASSERT(a_out_holds, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
    `IMHQ_ASSERT(a_take_leads, clk, rst_n, (in_valid && in_ready) |=> state_reg == imhq_pkg::S_POS_RD, "accept lost")
endmodule

// ===== hw/rtl/imhq_dp.sv =====
`include "indexed_min_heap_queue_top_macros.svh"
module imhq_dp #(
    parameter int Capacity = 1024,
    parameter int NodeIds = 1024,
    parameter int RankW = 32,
    parameter int IdW = 10,
    parameter int CntW = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  imhq_pkg::cmd_t   cmd,
    output imhq_pkg::stat_t  stat,
    input  logic [1:0]       in_op,
    input  logic [IdW-1:0]   in_node_id,
    input  logic [RankW-1:0] in_new_rank,
    input  logic             in_move_up,
    output logic [2:0]       status,
    output logic             top_valid,
    output logic [IdW-1:0]   top_node,
    output logic [RankW-1:0] top_rank,
    output logic [CntW-1:0]  entry_total
);
    localparam int SlotAw = $clog2(Capacity);
    localparam int NodeAw = $clog2(NodeIds);
    // node_position word: valid flag and slot
    localparam int PosW = SlotAw + 1;
    localparam int SlotW = IdW + RankW;

    logic [1:0]       op_reg;
    logic [IdW-1:0]   id_reg;
    logic [RankW-1:0] rank_reg;
    logic             up_reg;
    logic [2:0]       status_reg, status_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [CntW-1:0]  hole_reg, hole_next;
    logic [CntW-1:0]  child_reg;
    logic [NodeAw:0]  clr_reg;
    logic             known;

    // slot memories: each RAM word holds node and rank together
    logic              s_we;
    logic [SlotAw-1:0] s_waddr, s_raddr;
    logic [SlotW-1:0]  s_wdata, s_rdata;
    // second copy, read for the right child or the last entry
    logic              s2_we;
    logic [SlotAw-1:0] s2_raddr;
    logic [SlotW-1:0]  s2_rdata;
    logic              p_we;
    logic [NodeAw-1:0] p_waddr, p_raddr;
    logic [PosW-1:0]   p_wdata, p_rdata;

    imhq_ram #(.Width(SlotW), .Depth(Capacity)) u_slot_a (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));
    imhq_ram #(.Width(SlotW), .Depth(Capacity)) u_slot_b (
        .clk(clk), .we(s2_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s2_raddr), .rdata(s2_rdata));
    imhq_ram #(.Width(PosW), .Depth(NodeIds)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));

    logic [IdW-1:0]   a_node, b_node;
    logic [RankW-1:0] a_rank, b_rank;
    assign a_node = s_rdata[SlotW-1 -: IdW];
    assign a_rank = s_rdata[RankW-1:0];
    assign b_node = s2_rdata[SlotW-1 -: IdW];
    assign b_rank = s2_rdata[RankW-1:0];

    logic [CntW-1:0] parent, lchild;
    logic [CntW:0]   lchild_w;
    assign parent = (hole_reg - CntW'(1)) >> 1;
    assign lchild_w = {hole_reg, 1'b1};
    assign lchild = lchild_w[CntW-1:0];

    logic pos_valid;
    logic [CntW-1:0] pos_slot;
    assign pos_valid = p_rdata[PosW-1];
    assign pos_slot = CntW'(p_rdata[SlotAw-1:0]);
    assign known = (CntW+1)'(id_reg) < (CntW+1)'(NodeIds);

    logic reject;
    always_comb
    begin
        reject = 1'b0;
        status_next = imhq_pkg::ST_OK;
        unique case (op_reg)
            imhq_pkg::OP_INSERT:
                priority if (!known)
                begin
                    reject = 1'b1; status_next = imhq_pkg::ST_ABSENT;
                end
                else if (pos_valid)
                begin
                    reject = 1'b1; status_next = imhq_pkg::ST_PRESENT;
                end
                else if (count_reg >= CntW'(Capacity))
                begin
                    reject = 1'b1; status_next = imhq_pkg::ST_FULL;
                end
            imhq_pkg::OP_REMOVE:
                if (count_reg == '0)
                begin
                    reject = 1'b1; status_next = imhq_pkg::ST_EMPTY;
                end
            imhq_pkg::OP_MODIFY:
                if (!known || !pos_valid)
                begin
                    reject = 1'b1; status_next = imhq_pkg::ST_ABSENT;
                end
            default: reject = 1'b1;
        endcase
    end

    // right child usable and strictly smaller than left
    logic take_right;
    logic [CntW:0] rchild_w;
    assign rchild_w = (CntW+1)'(child_reg) + (CntW+1)'(1);
    assign take_right = (rchild_w < (CntW+1)'(count_reg)) && (a_rank > b_rank);

    always_comb
    begin
        stat.clr_done    = clr_reg == (NodeAw+1)'(NodeIds - 1);
        stat.reject      = reject;
        stat.op          = op_reg;
        stat.go_up       = up_reg;
        stat.up_at_root  = hole_reg == '0;
        stat.up_move     = rank_reg < a_rank;
        stat.dn_no_child = {1'b0, lchild_w} >= (CntW+2)'(count_reg);
        stat.dn_move     = take_right ? (rank_reg > b_rank) : (rank_reg > a_rank);
        // count has already dropped by the time this is looked at
        stat.rm_to_empty = count_reg == '0;
    end

    // memory control
    always_comb
    begin
        s_we = 1'b0; s2_we = 1'b0;
        s_waddr = hole_reg[SlotAw-1:0];
        s_wdata = {id_reg, rank_reg};
        s_raddr = '0; s2_raddr = '0;
        p_we = 1'b0;
        p_waddr = id_reg[NodeAw-1:0];
        p_wdata = {1'b1, hole_reg[SlotAw-1:0]};
        p_raddr = id_reg[NodeAw-1:0];
        hole_next = hole_reg;
        count_next = count_reg;
        if (cmd.clr_step)
        begin
            p_we = 1'b1;
            p_waddr = clr_reg[NodeAw-1:0];
            p_wdata = '0;
        end
        if (cmd.cap_in)
        begin
            p_raddr = in_node_id[NodeAw-1:0];
        end
        if (cmd.decide && !reject)
        begin
            unique case (op_reg)
                imhq_pkg::OP_INSERT:
                begin
                    hole_next = count_reg;
                    count_next = count_reg + CntW'(1);
                end
                imhq_pkg::OP_MODIFY:
                    hole_next = (pos_slot >= count_reg) ? '0 : pos_slot;
                default: hole_next = '0;
            endcase
        end
        if (cmd.rm_rd)
        begin
            s_raddr = '0;
            s2_raddr = SlotAw'(count_reg - CntW'(1));
        end
        if (cmd.rm_cap)
        begin
            // clear valid of removed root
            p_we = 1'b1;
            p_waddr = a_node[NodeAw-1:0];
            p_wdata = '0;
            count_next = count_reg - CntW'(1);
        end
        if (cmd.up_rd)
        begin
            s_raddr = parent[SlotAw-1:0];
        end
        if (cmd.up_cmp && stat.up_move)
        begin
            s_we = 1'b1; s2_we = 1'b1;
            s_wdata = s_rdata;
            p_we = 1'b1;
            p_waddr = a_node[NodeAw-1:0];
            hole_next = parent;
        end
        if (cmd.dn_rd)
        begin
            s_raddr = lchild[SlotAw-1:0];
            s2_raddr = SlotAw'(lchild + CntW'(1));
        end
        if (cmd.dn_cmp && stat.dn_move)
        begin
            s_we = 1'b1; s2_we = 1'b1;
            s_wdata = take_right ? s2_rdata : s_rdata;
            p_we = 1'b1;
            p_waddr = take_right ? b_node[NodeAw-1:0] : a_node[NodeAw-1:0];
            hole_next = take_right ? rchild_w[CntW-1:0] : child_reg;
        end
        if (cmd.place)
        begin
            s_we = 1'b1; s2_we = 1'b1;
            p_we = 1'b1;
        end
        if (cmd.top_rd)
        begin
            s_raddr = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clr_step && !stat.clr_done)
            begin
                clr_reg <= clr_reg + (NodeAw+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        if (cmd.cap_in)
        begin
            op_reg <= in_op;
            id_reg <= in_node_id;
            rank_reg <= in_new_rank;
            up_reg <= in_move_up;
        end
        if (cmd.decide)
        begin
            status_reg <= status_next;
        end
        if (cmd.rm_last_cap)
        begin
            // last entry becomes the one sifted down from the root
            id_reg <= b_node;
            rank_reg <= b_rank;
        end
        if (cmd.dn_rd)
        begin
            child_reg <= lchild;
        end
        if (cmd.top_cap)
        begin
            top_node <= (count_reg != '0) ? a_node : '0;
            top_rank <= (count_reg != '0) ? a_rank : '0;
        end
    end

    assign status = status_reg;
    assign top_valid = count_reg != '0;
    assign entry_total = count_reg;

    `IMHQ_ASSERT(a_count_cap, clk, rst_n, count_reg <= CntW'(Capacity), "count over capacity")
    `IMHQ_ASSERT(a_count_step, clk, rst_n, (count_reg != $past(count_reg)) |-> ($past(cmd.decide) || $past(cmd.rm_cap)), "count moved outside an operation")
    `IMHQ_ASSERT(a_hole_bound, clk, rst_n, (cmd.up_cmp || cmd.dn_cmp) |-> hole_reg < count_reg, "hole beyond entries")
endmodule

// ===== verif/heap_checker.sv =====
`timescale 1ns / 1ps

module heap_checker (
    input logic        clk,
    input logic        rst_n,
    imhq_in_if.sink    in_mon,
    imhq_out_if.sink   out_mon,
    output int         fail_count,
    output int         pending_total
);
    localparam int CAP = 1024;
    localparam int IDS = 1024;

    typedef struct packed {
        logic [2:0]  status;
        logic        top_valid;
        logic [9:0]  top_node;
        logic [31:0] top_rank;
        logic [10:0] entry_total;
    } heap_report_t;

    logic [9:0]  heap_node [CAP];
    logic [31:0] heap_rank [CAP];
    int          where_is [IDS];
    bit          held [IDS];
    int          heap_size;
    heap_report_t expected_reports [$];

    assign pending_total = expected_reports.size();

    function automatic void place(int s, logic [9:0] n, logic [31:0] r);
        heap_node[s] = n;
        heap_rank[s] = r;
        where_is[n] = s;
        held[n] = 1'b1;
    endfunction

    function automatic void bubble_up(int h, logic [9:0] n, logic [31:0] r);
        int p;
        while (h != 0)
        begin
            p = (h - 1) / 2;
            if (r >= heap_rank[p])
                break;
            place(h, heap_node[p], heap_rank[p]);
            h = p;
        end
        place(h, n, r);
    endfunction

    function automatic void bubble_down(int h, logic [9:0] n, logic [31:0] r);
        int c;
        c = 2 * h + 1;
        while (c < heap_size)
        begin
            if (c + 1 < heap_size && heap_rank[c] > heap_rank[c + 1])
                c++;
            if (r <= heap_rank[c])
                break;
            place(h, heap_node[c], heap_rank[c]);
            h = c;
            c = 2 * h + 1;
        end
        place(h, n, r);
    endfunction

    function automatic heap_report_t apply_op(logic [1:0] op, logic [9:0] id,
                                              logic [31:0] r, logic up);
        heap_report_t rep;
        int h;
        rep = '0;
        rep.status = imhq_pkg::ST_OK;
        if (op == imhq_pkg::OP_INSERT)
        begin
            if (held[id])
                rep.status = imhq_pkg::ST_PRESENT;
            else if (heap_size >= CAP)
                rep.status = imhq_pkg::ST_FULL;
            else
            begin
                h = heap_size;
                heap_size++;
                bubble_up(h, id, r);
            end
        end
        else if (op == imhq_pkg::OP_REMOVE)
        begin
            if (heap_size == 0)
                rep.status = imhq_pkg::ST_EMPTY;
            else
            begin
                held[heap_node[0]] = 1'b0;
                heap_size--;
                if (heap_size != 0)
                    bubble_down(0, heap_node[heap_size], heap_rank[heap_size]);
            end
        end
        else if (op == imhq_pkg::OP_MODIFY)
        begin
            if (!held[id])
                rep.status = imhq_pkg::ST_ABSENT;
            else
            begin
                h = where_is[id];
                if (h >= heap_size)
                    h = 0;
                if (up)
                    bubble_up(h, id, r);
                else
                    bubble_down(h, id, r);
            end
        end
        if (heap_size != 0)
        begin
            rep.top_valid = 1'b1;
            rep.top_node = heap_node[0];
            rep.top_rank = heap_rank[0];
        end
        rep.entry_total = heap_size[10:0];
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_report_t got;
        heap_report_t want;
        if (!rst_n)
        begin
            heap_size = 0;
            foreach (held[i])
                held[i] = 1'b0;
            expected_reports.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                expected_reports.push_back(apply_op(in_mon.op, in_mon.node_id,
                                                    in_mon.new_rank, in_mon.move_up));
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.status, out_mon.top_valid, out_mon.top_node,
                        out_mon.top_rank, out_mon.entry_total};
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_total;
    int   idle_cycles = 0;
    int   tail;

    imhq_in_if  in_ch ();
    imhq_out_if out_ch ();

    indexed_min_heap_queue_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    heap_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch.sink),
        .out_mon       (out_ch.sink),
        .fail_count    (fail_count),
        .pending_total (pending_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: covers the clearing pass plus long stalls and gaps.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stalls in its own random pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (($urandom % 512) < 100)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_item(logic [1:0] op, logic [9:0] id, logic [31:0] r, logic up);
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.node_id  <= id;
        in_ch.new_rank <= r;
        in_ch.move_up  <= up;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic drop_valid_for(int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_rank();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int burst;
        int count;
        logic [1:0] op;
        logic [9:0] id;
        in_ch.valid = 1'b0;
        in_ch.op = imhq_pkg::OP_INSERT;
        in_ch.node_id = '0;
        in_ch.new_rank = '0;
        in_ch.move_up = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty remove, absent modify, extremes, ties, duplicates.
        send_item(imhq_pkg::OP_REMOVE, 10'd0, 32'd0, 1'b0);
        send_item(imhq_pkg::OP_MODIFY, 10'd5, 32'd1, 1'b1);
        send_item(imhq_pkg::OP_INSERT, 10'd1023, 32'hFFFF_FFFF, 1'b0);
        send_item(imhq_pkg::OP_INSERT, 10'd0, 32'd0, 1'b1);
        send_item(imhq_pkg::OP_INSERT, 10'd0, 32'd9, 1'b1);
        send_item(imhq_pkg::OP_INSERT, 10'd7, 32'd0, 1'b0);
        send_item(imhq_pkg::OP_INSERT, 10'd8, 32'd5, 1'b0);
        send_item(imhq_pkg::OP_INSERT, 10'd9, 32'd5, 1'b0);
        send_item(imhq_pkg::OP_NOP, 10'd9, 32'd5, 1'b0);
        send_item(imhq_pkg::OP_MODIFY, 10'd1023, 32'd1, 1'b1);
        send_item(imhq_pkg::OP_MODIFY, 10'd0, 32'hFFFF_FFFF, 1'b0);
        send_item(imhq_pkg::OP_MODIFY, 10'd8, 32'hAAAA_5555, 1'b0);
        send_item(imhq_pkg::OP_MODIFY, 10'd9, 32'h5555_AAAA, 1'b1);
        repeat (7) send_item(imhq_pkg::OP_REMOVE, 10'h3FF, 32'd0, 1'b1);

        // Random: mostly inserts and modifies of a small id pool, so hits are common.
        count = 0;
        while (count < 570)
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: op = imhq_pkg::OP_INSERT;
                    4, 5: op = imhq_pkg::OP_REMOVE;
                    9: op = ($urandom_range(0, 3) == 0) ? imhq_pkg::OP_NOP
                                                         : imhq_pkg::OP_MODIFY;
                    default: op = imhq_pkg::OP_MODIFY;
                endcase
                id = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
                send_item(op, id, pick_rank(), 1'($urandom));
                count++;
            end
            drop_valid_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
        end

        send_item(imhq_pkg::OP_INSERT, 10'd3, 32'd1, 1'b0);
        send_item(imhq_pkg::OP_INSERT, 10'd4, 32'd1, 1'b0);
        send_item(imhq_pkg::OP_INSERT, 10'd4, 32'd1, 1'b0);
        in_ch.valid <= 1'b0;

        // let the checker record the last transfer before polling
        @(posedge clk);
        while (pending_total != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 100)
        begin
            @(posedge clk);
            tail++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
